### hw/rtl/lfu_pkg.sv
// Shared constants, payload types and control structs for the LFU cache table.
`default_nettype none

package lfu_pkg;

    localparam int CAPACITY   = 16;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int COUNT_BITS = 32;
    localparam int CAP_BITS   = 5;

    localparam int IDX_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int RANK_BITS = IDX_BITS;
    localparam int FILL_BITS = $clog2(CAPACITY + 1);
    localparam int CNT_W     = (FILL_BITS > CAP_BITS) ? FILL_BITS : CAP_BITS;

    localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

    typedef logic [IDX_BITS-1:0]   idx_t;
    typedef logic [RANK_BITS-1:0]  rank_t;
    typedef logic [KEY_BITS-1:0]   key_t;
    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [COUNT_BITS-1:0] count_t;

    localparam count_t COUNT_MAX = '1;

    typedef enum logic {
        MODE_GET = 1'b0,
        MODE_PUT = 1'b1
    } mode_t;

    typedef struct packed {
        logic   mode;
        key_t   lookup_key;
        value_t write_value;
    } in_word_t;

    typedef struct packed {
        logic   hit;
        value_t read_value;
        logic   evicted;
        key_t   evicted_key;
    } out_word_t;

    // One table entry as seen at the read port of the store.
    typedef struct packed {
        logic   valid;
        key_t   key;
        value_t value;
        count_t count;
        rank_t  rank;
    } entry_t;

    // Results gathered by the scan over all entries.
    typedef struct packed {
        logic   hit_found;
        idx_t   hit_idx;
        value_t hit_value;
        count_t hit_count;
        rank_t  hit_rank;
        logic   free_found;
        idx_t   free_idx;
        logic   vic_found;
        idx_t   vic_idx;
        key_t   vic_key;
        rank_t  vic_rank;
    } scan_t;

    typedef enum logic [2:0] {
        UPD_NONE      = 3'd0,
        UPD_GET_TOUCH = 3'd1,
        UPD_PUT_TOUCH = 3'd2,
        UPD_INSERT    = 3'd3,
        UPD_REPLACE   = 3'd4
    } upd_op_t;

    // Update command applied to the store.
    typedef struct packed {
        upd_op_t op;
        idx_t    slot;
        rank_t   pivot;
        key_t    key;
        value_t  value;
        count_t  count;
    } upd_t;

endpackage

`default_nettype wire

### hw/rtl/lfu_store.sv
// Entry storage: valid bits, keys, values, use counts and recency ranks.
`default_nettype none

module lfu_store (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire lfu_pkg::idx_t rd_idx,
    output lfu_pkg::entry_t    rd_entry,
    input  wire lfu_pkg::upd_t upd
);
    import lfu_pkg::*;

    logic [CAPACITY-1:0] valid_reg;
    logic [CAPACITY-1:0] valid_next;
    key_t   key_reg   [CAPACITY];
    value_t value_reg [CAPACITY];
    count_t count_reg [CAPACITY];
    rank_t  rank_reg  [CAPACITY];
    rank_t  rank_next [CAPACITY];

    always_comb begin
        rd_entry.valid = valid_reg[rd_idx];
        rd_entry.key   = key_reg[rd_idx];
        rd_entry.value = value_reg[rd_idx];
        rd_entry.count = count_reg[rd_idx];
        rd_entry.rank  = rank_reg[rd_idx];
    end

    // Every entry adjusts its own rank in parallel, against the pivot on a touch or a replace.
    always_comb begin
        for (int j = 0; j < CAPACITY; j++) begin
            rank_next[j] = rank_reg[j];
            unique case (upd.op)
                UPD_GET_TOUCH, UPD_PUT_TOUCH: begin
                    if (valid_reg[j] && (rank_reg[j] < upd.pivot)) begin
                        rank_next[j] = rank_reg[j] + RANK_BITS'(1);
                    end
                end
                UPD_INSERT: begin
                    if (valid_reg[j]) begin
                        rank_next[j] = rank_reg[j] + RANK_BITS'(1);
                    end
                end
                UPD_REPLACE: begin
                    if (valid_reg[j] && (IDX_BITS'(j) != upd.slot) &&
                        !(rank_reg[j] > upd.pivot)) begin
                        rank_next[j] = rank_reg[j] + RANK_BITS'(1);
                    end
                end
                UPD_NONE: begin
                end
                default: begin
                end
            endcase
            if ((upd.op != UPD_NONE) && (IDX_BITS'(j) == upd.slot)) begin
                rank_next[j] = '0;
            end
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if ((upd.op == UPD_INSERT) || (upd.op == UPD_REPLACE)) begin
            valid_next[upd.slot] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < CAPACITY; j++) begin
            rank_reg[j] <= rank_next[j];
        end
        unique case (upd.op)
            UPD_GET_TOUCH: begin
                count_reg[upd.slot] <= upd.count;
            end
            UPD_PUT_TOUCH: begin
                count_reg[upd.slot] <= upd.count;
                value_reg[upd.slot] <= upd.value;
            end
            UPD_INSERT, UPD_REPLACE: begin
                key_reg[upd.slot]   <= upd.key;
                value_reg[upd.slot] <= upd.value;
                count_reg[upd.slot] <= upd.count;
            end
            UPD_NONE: begin
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/lfu_scan.sv
// Scan unit: one key compare, one free check and one victim compare applied to one entry per cycle while enabled.
`default_nettype none

module lfu_scan (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            clr,
    input  wire logic            en,
    input  wire lfu_pkg::idx_t   idx,
    input  wire lfu_pkg::entry_t entry,
    input  wire lfu_pkg::key_t   key,
    output lfu_pkg::scan_t       result
);
    import lfu_pkg::*;

    logic   hit_found_reg;
    logic   free_found_reg;
    logic   vic_found_reg;
    idx_t   hit_idx_reg;
    value_t hit_value_reg;
    count_t hit_count_reg;
    rank_t  hit_rank_reg;
    idx_t   free_idx_reg;
    idx_t   vic_idx_reg;
    key_t   vic_key_reg;
    count_t vic_count_reg;
    rank_t  vic_rank_reg;

    logic take_hit;
    logic take_free;
    logic take_vic;

    // The victim is the lowest count; among equal counts the largest rank wins.
    always_comb begin
        take_hit  = en && entry.valid && (entry.key == key) && !hit_found_reg;
        take_free = en && !entry.valid && !free_found_reg;
        take_vic  = en && entry.valid &&
                    (!vic_found_reg || (entry.count < vic_count_reg) ||
                     ((entry.count == vic_count_reg) && (entry.rank > vic_rank_reg)));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            vic_found_reg  <= 1'b0;
        end else if (clr) begin
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            vic_found_reg  <= 1'b0;
        end else begin
            if (take_hit) begin
                hit_found_reg <= 1'b1;
            end
            if (take_free) begin
                free_found_reg <= 1'b1;
            end
            if (take_vic) begin
                vic_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take_hit) begin
            hit_idx_reg   <= idx;
            hit_value_reg <= entry.value;
            hit_count_reg <= entry.count;
            hit_rank_reg  <= entry.rank;
        end
        if (take_free) begin
            free_idx_reg <= idx;
        end
        if (take_vic) begin
            vic_idx_reg   <= idx;
            vic_key_reg   <= entry.key;
            vic_count_reg <= entry.count;
            vic_rank_reg  <= entry.rank;
        end
    end

    always_comb begin
        result.hit_found  = hit_found_reg;
        result.hit_idx    = hit_idx_reg;
        result.hit_value  = hit_value_reg;
        result.hit_count  = hit_count_reg;
        result.hit_rank   = hit_rank_reg;
        result.free_found = free_found_reg;
        result.free_idx   = free_idx_reg;
        result.vic_found  = vic_found_reg;
        result.vic_idx    = vic_idx_reg;
        result.vic_key    = vic_key_reg;
        result.vic_rank   = vic_rank_reg;
    end

endmodule

`default_nettype wire

### hw/rtl/lfu_cache_table.sv
// Top level of the LFU cache table: handshakes, sequencer and the apply step.
//
//  Channel   Direction  Ports                      Word
//  --------  ---------  -------------------------  -----------------------------------
//  input     in         s_valid s_ready s_data     mode, lookup_key, write_value
//  result    out        m_valid m_ready m_data     hit, read_value, evicted, evicted_key
//  config    in         cfg_we cfg_wdata           capacity_in_use
//
// A word occupies the block from acceptance until it is back in idle: the scan visits every
// entry in turn through the shared scan unit, then the apply state updates the table.
// The result is registered when the apply step goes ahead; no new word is taken meanwhile.
// Reset is synchronous and active low; it clears the valid bits, the fill count and the
// result valid flag, and sets the capacity to 16. No clearing pass is needed.
// The apply step, and with it the input, waits while a finished result is still untaken.
`default_nettype none

module lfu_cache_table (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire lfu_pkg::in_word_t         s_data,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output lfu_pkg::out_word_t             m_data,
    input  wire logic                      cfg_we,
    input  wire logic [lfu_pkg::CAP_BITS-1:0] cfg_wdata
);
    import lfu_pkg::*;

    // One-hot sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_APPLY = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [CAP_BITS-1:0]  cap_reg;
    logic [FILL_BITS-1:0] filled_reg;
    logic [FILL_BITS-1:0] filled_next;
    idx_t                 scan_idx_reg;
    idx_t                 scan_idx_next;
    in_word_t             item_reg;
    out_word_t            out_reg;
    out_word_t            out_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;

    logic      accept;
    logic      scan_last;
    logic      apply_go;
    entry_t    rd_entry;
    scan_t     scan_res;
    upd_t      upd;
    logic [CNT_W-1:0] cap_ext;
    logic [CNT_W-1:0] cap_eff;
    logic [CNT_W-1:0] filled_ext;
    count_t    count_inc;

    lfu_store u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_idx   (scan_idx_reg),
        .rd_entry (rd_entry),
        .upd      (upd)
    );

    lfu_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clr     (accept),
        .en      (state_reg == ST_SCAN),
        .idx     (scan_idx_reg),
        .entry   (rd_entry),
        .key     (item_reg.lookup_key),
        .result  (scan_res)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    assign scan_last = (scan_idx_reg == IDX_BITS'(CAPACITY - 1));
    // The table is only changed once the result register is free to take the word.
    assign apply_go  = (state_reg == ST_APPLY) && (!out_valid_reg || m_ready);

    // A capacity above the table size acts as the table size.
    always_comb begin
        cap_ext    = CNT_W'(cap_reg);
        filled_ext = CNT_W'(filled_reg);
        cap_eff    = (cap_ext > CNT_W'(CAPACITY)) ? CNT_W'(CAPACITY) : cap_ext;
        count_inc  = (scan_res.hit_count == COUNT_MAX) ? scan_res.hit_count :
                     scan_res.hit_count + COUNT_BITS'(1);
    end

    // Decide what the word does to the table and what it reports.
    always_comb begin
        upd.op    = UPD_NONE;
        upd.slot  = scan_res.hit_idx;
        upd.pivot = scan_res.hit_rank;
        upd.key   = item_reg.lookup_key;
        upd.value = item_reg.write_value;
        upd.count = count_inc;

        out_next.hit         = scan_res.hit_found;
        out_next.read_value  = '0;
        out_next.evicted     = 1'b0;
        out_next.evicted_key = '0;

        filled_next = filled_reg;

        if (apply_go) begin
            if (item_reg.mode == MODE_GET) begin
                // A get that hits returns the value and refreshes the entry.
                if (scan_res.hit_found) begin
                    upd.op              = UPD_GET_TOUCH;
                    out_next.read_value = scan_res.hit_value;
                end
            end else if (cap_eff != '0) begin
                if (scan_res.hit_found) begin
                    upd.op = UPD_PUT_TOUCH;
                end else if ((filled_ext < cap_eff) && scan_res.free_found) begin
                    // A new key takes the lowest free slot with a count of one.
                    upd.op      = UPD_INSERT;
                    upd.slot    = scan_res.free_idx;
                    upd.count   = COUNT_BITS'(1);
                    filled_next = filled_reg + FILL_BITS'(1);
                end else if (scan_res.vic_found) begin
                    // The table is full, so the victim's slot is reused and the
                    // fill count stays where it is.
                    upd.op               = UPD_REPLACE;
                    upd.slot             = scan_res.vic_idx;
                    upd.pivot            = scan_res.vic_rank;
                    upd.count            = COUNT_BITS'(1);
                    out_next.evicted     = 1'b1;
                    out_next.evicted_key = scan_res.vic_key;
                end
            end
        end
    end

    always_comb begin
        state_next    = state_reg;
        scan_idx_next = scan_idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next    = ST_SCAN;
                    scan_idx_next = '0;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = ST_APPLY;
                end else begin
                    scan_idx_next = scan_idx_reg + IDX_BITS'(1);
                end
            end
            ST_APPLY: begin
                if (apply_go) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (apply_go) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cap_reg       <= CAP_RESET;
            filled_reg    <= '0;
            out_valid_reg <= 1'b0;
            scan_idx_reg  <= '0;
        end else begin
            state_reg     <= state_next;
            filled_reg    <= filled_next;
            out_valid_reg <= out_valid_next;
            scan_idx_reg  <= scan_idx_next;
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_data;
        end
        if (apply_go) begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the LFU cache table: predictor, driver, monitor and stimulus.
`default_nettype none

module tb;
    import lfu_pkg::*;

    // Cycles of silence on both channels after which the run is declared hung.
    // The worst legitimate gap is the long receiver hold plus a couple of words.
    localparam int QUIET_LIMIT  = 3000;
    // This margin lets the last word finish in the block before a register write and
    // at the end of the run.
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_AFTER    = 150;
    localparam int HOLD_CYCLES   = 400;
    localparam int KEY_POOL_SIZE = 24;
    localparam int PHASES        = 8;

    // Idle patterns: sender-light, receiver-light, and no idling at all.
    localparam int IDLE_SENDER_LIGHT   = 0;
    localparam int IDLE_RECEIVER_LIGHT = 1;
    localparam int IDLE_NONE           = 2;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    in_word_t            s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    out_word_t           m_data;
    logic                cfg_we    = 1'b0;
    logic [CAP_BITS-1:0] cfg_wdata = '0;

    // Words waiting to be offered, and the results they are predicted to give.
    in_word_t  pending_words[$];
    out_word_t expected_words[$];

    int fail_count   = 0;
    int results_seen = 0;
    int quiet_cycles = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    int idle_mode    = IDLE_SENDER_LIGHT;

    // Shadow copy of the table kept by the predictor.
    logic                tbl_valid [CAPACITY];
    key_t                tbl_key   [CAPACITY];
    value_t              tbl_value [CAPACITY];
    count_t              tbl_count [CAPACITY];
    rank_t               tbl_rank  [CAPACITY];
    logic [FILL_BITS-1:0] tbl_filled;
    logic [CAP_BITS-1:0]  cap_setting;

    key_t key_pool[KEY_POOL_SIZE];

    // Random phases: capacity written before the phase, word count, idle pattern.
    // Capacity 31 lies above the table size, and 3 after 9 shrinks below occupancy.
    int unsigned phase_cap  [PHASES] = '{31, 4, 1, 16, 0, 9, 3, 16};
    int unsigned phase_words[PHASES] = '{300, 250, 150, 300, 100, 300, 200, 200};
    int          phase_idle [PHASES] = '{IDLE_SENDER_LIGHT, IDLE_SENDER_LIGHT,
                                         IDLE_RECEIVER_LIGHT, IDLE_RECEIVER_LIGHT,
                                         IDLE_RECEIVER_LIGHT, IDLE_NONE, IDLE_NONE,
                                         IDLE_NONE};

    lfu_cache_table DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // A hit bumps the use count, saturating at the top, and moves the entry to
    // rank zero; every entry that was more recent slides back by one.
    function automatic void bump_entry(int i);
        rank_t old_rank;
        int    j;
        old_rank = tbl_rank[i];
        if (tbl_count[i] != COUNT_MAX)
            tbl_count[i] = tbl_count[i] + 1'b1;
        for (j = 0; j < CAPACITY; j++) begin
            if (tbl_valid[j] && tbl_rank[j] < old_rank)
                tbl_rank[j] = tbl_rank[j] + 1'b1;
        end
        tbl_rank[i] = '0;
    endfunction

    // Applies one word to the shadow table and returns the result it must give.
    function automatic out_word_t predict_result(in_word_t w);
        out_word_t res;
        int        found;
        int        slot;
        int        victim;
        int        eff_cap;
        int        j;
        rank_t     gone_rank;
        res   = '0;
        found = -1;
        slot  = -1;
        victim = -1;
        for (j = 0; j < CAPACITY; j++) begin
            if (found < 0 && tbl_valid[j] && tbl_key[j] == w.lookup_key)
                found = j;
        end
        res.hit = (found >= 0);

        if (w.mode == MODE_GET) begin
            if (found >= 0) begin
                bump_entry(found);
                res.read_value = tbl_value[found];
            end
            return res;
        end

        // Settings above the table size behave as the full table; zero freezes it.
        eff_cap = (cap_setting > CAPACITY) ? CAPACITY : int'(cap_setting);
        if (eff_cap == 0)
            return res;

        if (found >= 0) begin
            tbl_value[found] = w.write_value;
            bump_entry(found);
            return res;
        end

        // A new key takes the lowest free slot while there is room under the
        // current capacity.
        if (tbl_filled < eff_cap) begin
            for (j = 0; j < CAPACITY; j++) begin
                if (slot < 0 && !tbl_valid[j])
                    slot = j;
            end
        end

        // Otherwise the least used entry goes, the oldest one among equal counts.
        // This also covers a capacity lowered below the current occupancy.
        if (slot < 0) begin
            for (j = 0; j < CAPACITY; j++) begin
                if (tbl_valid[j] && (victim < 0 || tbl_count[j] < tbl_count[victim] ||
                    (tbl_count[j] == tbl_count[victim] && tbl_rank[j] > tbl_rank[victim])))
                    victim = j;
            end
            if (victim < 0)
                return res;
            gone_rank = tbl_rank[victim];
            res.evicted     = 1'b1;
            res.evicted_key = tbl_key[victim];
            tbl_valid[victim] = 1'b0;
            for (j = 0; j < CAPACITY; j++) begin
                if (tbl_valid[j] && tbl_rank[j] > gone_rank)
                    tbl_rank[j] = tbl_rank[j] - 1'b1;
            end
            if (tbl_filled != 0)
                tbl_filled = tbl_filled - 1'b1;
            slot = victim;
        end

        for (j = 0; j < CAPACITY; j++) begin
            if (tbl_valid[j])
                tbl_rank[j] = tbl_rank[j] + 1'b1;
        end
        tbl_valid[slot] = 1'b1;
        tbl_key[slot]   = w.lookup_key;
        tbl_value[slot] = w.write_value;
        tbl_count[slot] = count_t'(1);
        tbl_rank[slot]  = '0;
        tbl_filled      = tbl_filled + 1'b1;
        return res;
    endfunction

    function automatic bit sender_idles();
        case (idle_mode)
            IDLE_SENDER_LIGHT:   return $urandom_range(99) < 26;
            IDLE_RECEIVER_LIGHT: return $urandom_range(99) < 49;
            default:             return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_idles();
        case (idle_mode)
            IDLE_SENDER_LIGHT:   return $urandom_range(99) < 49;
            IDLE_RECEIVER_LIGHT: return $urandom_range(99) < 26;
            default:             return 1'b0;
        endcase
    endfunction

    // Driver. The prediction is made at the edge that accepts the word, so the
    // expected results line up in acceptance order. A new word is loaded only
    // when the slot is free, so valid holds steady while the block stalls.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                expected_words.push_back(predict_result(s_data));
            if (!s_valid || s_ready) begin
                if (pending_words.size() != 0 && !sender_idles()) begin
                    s_data  <= pending_words.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        fail_count++;
    endtask

    // Monitor. It checks every accepted result against the oldest prediction and
    // drives ready. Once, after HOLD_AFTER results, it holds ready low for a long
    // stretch while the driver keeps offering words, so the block fills and
    // pushes back on its input.
    always @(posedge aclk) begin
        out_word_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: result with nothing expected, actual %h", $time, m_data);
                    fail_count++;
                end else begin
                    want = expected_words.pop_front();
                    if (m_data.hit !== want.hit)
                        report_mismatch("hit", 32'(want.hit), 32'(m_data.hit));
                    if (m_data.read_value !== want.read_value)
                        report_mismatch("read_value", want.read_value, m_data.read_value);
                    if (m_data.evicted !== want.evicted)
                        report_mismatch("evicted", 32'(want.evicted), 32'(m_data.evicted));
                    if (m_data.evicted_key !== want.evicted_key)
                        report_mismatch("evicted_key", want.evicted_key, m_data.evicted_key);
                end
                results_seen++;
            end
            if (hold_left != 0) begin
                m_ready   <= 1'b0;
                hold_left = hold_left - 1;
            end else if (!hold_done && results_seen == HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_ready   <= 1'b0;
            end else begin
                m_ready <= !receiver_idles();
            end
        end
    end

    // Watchdog: too long without a single handshake means the block is stuck.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("lfu_cache_table regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_word(logic mode, key_t key, value_t value);
        in_word_t w;
        w.mode        = mode;
        w.lookup_key  = key;
        w.write_value = value;
        pending_words.push_back(w);
    endtask

    // Mostly keys from a small pool sized to the capacity, so gets hit and
    // evictions happen; a few fully random keys keep every key bit moving.
    task automatic queue_random(int count, int span);
        int   i;
        key_t key;
        for (i = 0; i < count; i++) begin
            if ($urandom_range(99) < 8)
                key = $urandom;
            else
                key = key_pool[$urandom_range(span - 1)];
            queue_word(($urandom_range(99) < 50) ? MODE_PUT : MODE_GET, key, $urandom);
        end
    endtask

    // Sampling on the falling edge keeps this clear of the posedge updates.
    task automatic wait_drained();
        @(negedge aclk);
        while (pending_words.size() != 0 || expected_words.size() != 0 || s_valid)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // The block is idle whenever this is called, so the predictor may take the
    // new capacity at once.
    task automatic write_capacity(logic [CAP_BITS-1:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cap_setting = value;
    endtask

    initial begin
        int p;
        int span;
        for (p = 0; p < CAPACITY; p++)
            tbl_valid[p] = 1'b0;
        tbl_filled  = '0;
        cap_setting = CAP_RESET;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (p = 2; p < KEY_POOL_SIZE; p++)
            key_pool[p] = $urandom;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed words at the reset capacity: a miss on the empty table, the
        // key and value extremes, a put that hits, and a miss on a table that holds entries.
        queue_word(MODE_GET, 32'h0000_0000, 32'h0000_0000);
        queue_word(MODE_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_word(MODE_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_word(MODE_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_word(MODE_GET, 32'h0000_0000, 32'h0000_0000);
        queue_word(MODE_PUT, 32'h0000_0000, 32'hA5A5_A5A5);
        queue_word(MODE_GET, 32'h0000_1234, 32'h0000_0000);
        wait_drained();

        // Capacity zero: puts change nothing, but hits are still reported.
        write_capacity(5'd0);
        queue_word(MODE_PUT, 32'h0000_0077, 32'h0000_0001);
        queue_word(MODE_PUT, 32'h0000_0000, 32'h0000_0005);
        queue_word(MODE_GET, 32'h0000_0000, 32'h0000_0000);
        queue_word(MODE_GET, 32'h0000_0077, 32'h0000_0000);
        wait_drained();

        // Capacity one with two entries held: each new key evicts exactly one.
        write_capacity(5'd1);
        queue_word(MODE_PUT, 32'h0000_0077, 32'h5A5A_5A5A);
        queue_word(MODE_PUT, 32'h0000_0088, 32'h0F0F_0F0F);
        queue_word(MODE_GET, 32'h0000_0088, 32'h0000_0000);
        queue_word(MODE_PUT, 32'h0000_0099, 32'hF0F0_F0F0);
        wait_drained();

        // Capacity three: a free slot first, then ties on count broken by age.
        write_capacity(5'd3);
        queue_word(MODE_PUT, 32'h0000_0011, 32'h1111_1111);
        queue_word(MODE_PUT, 32'h0000_0022, 32'h2222_2222);
        queue_word(MODE_GET, 32'h0000_0011, 32'h0000_0000);
        queue_word(MODE_PUT, 32'h0000_0033, 32'h3333_3333);
        queue_word(MODE_GET, 32'h0000_0000, 32'h0000_0000);
        queue_word(MODE_PUT, 32'h0000_0044, 32'h4444_4444);
        wait_drained();

        // Saturation of the 32-bit use count is out of reach in a run this long.
        for (p = 0; p < PHASES; p++) begin
            write_capacity(phase_cap[p][CAP_BITS-1:0]);
            idle_mode <= phase_idle[p];
            span = (phase_cap[p] > CAPACITY) ? CAPACITY : phase_cap[p];
            span = (span == 0) ? 6 : span + 4;
            if (span > KEY_POOL_SIZE)
                span = KEY_POOL_SIZE;
            queue_random(phase_words[p], span);
            wait_drained();
        end

        if (fail_count == 0 && expected_words.size() == 0) begin
            $display("lfu_cache_table regression: pass");
        end else begin
            $display("lfu_cache_table regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
